FILE: sv/ipv6lpm_pkg.sv
// Shared constants for the IPv6 stride-8 trie lookup.
package ipv6lpm_pkg;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 20;
    localparam int HOP_OUT_BITS   = 20;
    localparam int LEVEL_BITS     = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOT_NODE        = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_ENABLE   = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_NEXT_HOP = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IPV6_MODE        = 8'd3;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam logic [7:0]            CHILD_NONE = 8'd0;
    localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = 4'd15;

endpackage

FILE: sv/ipv6_stride8_trie_lpm_lookup.sv
// Top level: IPv6 longest-prefix-match walk over a stride-8 multibit trie.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  kind, addr_hi, addr_lo, node_index,
//                                              entry_byte, child_index, entry_valid,
//                                              entry_next_hop
//   rsp      out        rsp_valid / rsp_stall  hit, fwd_hop, from_default
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A table write is done in the cycle it is accepted. A lookup walks L levels (1..16,
// 0 with ipv6_mode off) in turn: the entry RAM has one registered read port and
// each level's address comes from the previous level's entry.
// After reset a clearing pass writes all NODES*256 entries, one per cycle, with
// req_stall high; configuration writes are taken throughout.
// A finished result waits in the FINISH state while the rsp register is stalled.
module ipv6_stride8_trie_lpm_lookup
    import ipv6lpm_pkg::*;
#(
    parameter int NODES         = 256,
    parameter int NEXT_HOP_BITS = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic                      kind,
    input  logic [63:0]               addr_hi,
    input  logic [63:0]               addr_lo,
    input  logic [7:0]                node_index,
    input  logic [7:0]                entry_byte,
    input  logic [7:0]                child_index,
    input  logic                      entry_valid,
    input  logic [19:0]               entry_next_hop,

    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic                      hit,
    output logic [HOP_OUT_BITS-1:0]   fwd_hop,
    output logic                      from_default,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int NW    = $clog2(NODES);
    localparam int AW    = NW + 8;
    localparam int DEPTH = NODES * 256;
    localparam int EW    = 8 + 1 + NEXT_HOP_BITS;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_FINISH} state_t;

    function automatic logic [AW-1:0] entry_addr(input logic [7:0] node,
                                                 input logic [7:0] sel);
        logic [NW+7:0] wide;
        wide = {{NW{1'b0}}, node};
        return {wide[NW-1:0], sel};
    endfunction

    function automatic logic node_in_range(input logic [7:0] node);
        return {24'd0, node} < 32'(NODES);
    endfunction

    function automatic logic [NEXT_HOP_BITS-1:0] hop_cut(input logic [19:0] hop);
        logic [NEXT_HOP_BITS+19:0] wide;
        wide = {{NEXT_HOP_BITS{1'b0}}, hop};
        return wide[NEXT_HOP_BITS-1:0];
    endfunction

    function automatic logic [HOP_OUT_BITS-1:0] hop_out(input logic [NEXT_HOP_BITS-1:0] hop);
        logic [NEXT_HOP_BITS+HOP_OUT_BITS-1:0] wide;
        wide = {{HOP_OUT_BITS{1'b0}}, hop};
        return wide[HOP_OUT_BITS-1:0];
    endfunction

    state_t                      state_reg, state_next;
    logic [AW-1:0]               clear_addr_reg, clear_addr_next;
    logic [LEVEL_BITS-1:0]       level_reg, level_next;
    logic [127:0]                addr_reg, addr_next;
    logic                        oob_reg, oob_next;
    logic                        found_reg, found_next;
    logic [NEXT_HOP_BITS-1:0]    hop_reg, hop_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic                        hit_reg, hit_next;
    logic [HOP_OUT_BITS-1:0]     fwd_hop_reg, fwd_hop_next;
    logic                        from_default_reg, from_default_next;

    logic [7:0]                  root_node_reg, root_node_next;
    logic                        default_enable_reg, default_enable_next;
    logic [19:0]                 default_next_hop_reg, default_next_hop_next;
    logic                        ipv6_mode_reg, ipv6_mode_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [EW-1:0]               ram_rdata;

    logic                        req_fire;
    logic                        rsp_fire;
    logic [7:0]                  ent_child;
    logic                        ent_valid;
    logic [NEXT_HOP_BITS-1:0]    ent_hop;

    ipv6lpm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall    = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign rsp_valid    = rsp_valid_reg;
    assign hit          = hit_reg;
    assign fwd_hop      = fwd_hop_reg;
    assign from_default = from_default_reg;

    assign req_fire = req_valid && !req_stall;
    assign rsp_fire = rsp_valid_reg && !rsp_stall;

    // An entry fetched for a node beyond the store reads as empty.
    assign ent_child = oob_reg ? CHILD_NONE : ram_rdata[NEXT_HOP_BITS+8:NEXT_HOP_BITS+1];
    assign ent_valid = !oob_reg && ram_rdata[NEXT_HOP_BITS];
    assign ent_hop   = ram_rdata[NEXT_HOP_BITS-1:0];

    always_comb
    begin
        state_next            = state_reg;
        clear_addr_next       = clear_addr_reg;
        level_next            = level_reg;
        addr_next             = addr_reg;
        oob_next              = oob_reg;
        found_next            = found_reg;
        hop_next              = hop_reg;
        rsp_valid_next        = rsp_valid_reg;
        hit_next              = hit_reg;
        fwd_hop_next          = fwd_hop_reg;
        from_default_next     = from_default_reg;
        root_node_next        = root_node_reg;
        default_enable_next   = default_enable_reg;
        default_next_hop_next = default_next_hop_reg;
        ipv6_mode_next        = ipv6_mode_reg;
        ram_we                = 1'b0;
        ram_waddr             = '0;
        ram_wdata             = '0;
        ram_re                = 1'b0;
        ram_raddr             = '0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROOT_NODE:        root_node_next        = cfg_data[7:0];
                CFG_DEFAULT_ENABLE:   default_enable_next   = cfg_data[0];
                CFG_DEFAULT_NEXT_HOP: default_next_hop_next = cfg_data[19:0];
                CFG_IPV6_MODE:        ipv6_mode_next        = cfg_data[0];
                default: ;
            endcase
        end

        if (rsp_fire)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clear_addr_reg;
                if (clear_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (kind == KIND_WRITE)
                    begin
                        // Drop writes to nodes beyond the store.
                        if (node_in_range(node_index))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = entry_addr(node_index, entry_byte);
                            ram_wdata = {child_index, entry_valid, hop_cut(entry_next_hop)};
                        end
                    end
                    else
                    begin
                        found_next = 1'b0;
                        hop_next   = '0;
                        level_next = '0;
                        addr_next  = {addr_hi[55:0], addr_lo, 8'h00};
                        if (ipv6_mode_reg)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = entry_addr(root_node_reg, addr_hi[63:56]);
                            oob_next   = !node_in_range(root_node_reg);
                            state_next = ST_LOOK;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_LOOK:
            begin
                if (ent_valid)
                begin
                    found_next = 1'b1;
                    hop_next   = ent_hop;
                end
                if (level_reg == LAST_LEVEL || ent_child == CHILD_NONE)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // Descend: fetch the child's entry for the next address byte.
                    ram_re     = 1'b1;
                    ram_raddr  = entry_addr(ent_child, addr_reg[127:120]);
                    oob_next   = !node_in_range(ent_child);
                    addr_next  = {addr_reg[119:0], 8'h00};
                    level_next = level_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next    = 1'b1;
                    hit_next          = 1'b0;
                    fwd_hop_next      = '0;
                    from_default_next = 1'b0;
                    if (ipv6_mode_reg)
                    begin
                        if (found_reg)
                        begin
                            hit_next     = 1'b1;
                            fwd_hop_next = hop_out(hop_reg);
                        end
                        else if (default_enable_reg)
                        begin
                            hit_next          = 1'b1;
                            fwd_hop_next      = hop_out(hop_cut(default_next_hop_reg));
                            from_default_next = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_CLEAR;
            clear_addr_reg       <= '0;
            level_reg            <= '0;
            addr_reg             <= '0;
            oob_reg              <= 1'b0;
            found_reg            <= 1'b0;
            hop_reg              <= '0;
            rsp_valid_reg        <= 1'b0;
            hit_reg              <= 1'b0;
            fwd_hop_reg          <= '0;
            from_default_reg     <= 1'b0;
            root_node_reg        <= 8'd0;
            default_enable_reg   <= 1'b0;
            default_next_hop_reg <= 20'd0;
            ipv6_mode_reg        <= 1'b1;
        end
        else
        begin
            state_reg            <= state_next;
            clear_addr_reg       <= clear_addr_next;
            level_reg            <= level_next;
            addr_reg             <= addr_next;
            oob_reg              <= oob_next;
            found_reg            <= found_next;
            hop_reg              <= hop_next;
            rsp_valid_reg        <= rsp_valid_next;
            hit_reg              <= hit_next;
            fwd_hop_reg          <= fwd_hop_next;
            from_default_reg     <= from_default_next;
            root_node_reg        <= root_node_next;
            default_enable_reg   <= default_enable_next;
            default_next_hop_reg <= default_next_hop_next;
            ipv6_mode_reg        <= ipv6_mode_next;
        end
    end

    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !rsp_valid_reg)
        else $error("response raised during clearing pass");

    a_default_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && from_default_reg) |-> hit_reg)
        else $error("default route answer without hit");

    a_miss_zero_hop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !hit_reg) |-> (fwd_hop_reg == '0))
        else $error("miss carries a nonzero next hop");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && kind == KIND_LOOKUP) |=> (state_reg == ST_LOOK || state_reg == ST_FINISH))
        else $error("accepted lookup did not start a walk");

    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> !ram_we)
        else $error("entry RAM written during a walk");

endmodule

FILE: sv/ipv6lpm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ipv6lpm_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: tb/lpm_route_checker.sv
// Channel monitor and route predictor for the stride-8 IPv6 trie lookup.
`timescale 1ns / 100ps

module lpm_route_checker
    import ipv6lpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      req_valid,
    input  logic                      req_stall,
    input  logic                      kind,
    input  logic [63:0]               addr_hi,
    input  logic [63:0]               addr_lo,
    input  logic [7:0]                node_index,
    input  logic [7:0]                entry_byte,
    input  logic [7:0]                child_index,
    input  logic                      entry_valid,
    input  logic [19:0]               entry_next_hop,

    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  logic                      hit,
    input  logic [HOP_OUT_BITS-1:0]   fwd_hop,
    input  logic                      from_default,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    output int                        mismatches,
    output int                        pending,
    output int                        lookups_seen,
    output int                        writes_seen,
    output int                        routed,
    output int                        defaulted
);

    typedef struct packed {
        logic                    hit;
        logic [HOP_OUT_BITS-1:0] fwd_hop;
        logic                    from_default;
    } route_answer_t;

    // shadow of the node store, indexed by {node, address byte}
    logic [7:0]              tbl_child [0:65535];
    logic                    tbl_valid [0:65535];
    logic [19:0]             tbl_hop   [0:65535];

    logic [7:0]              trie_root;
    logic                    dflt_on;
    logic [19:0]             dflt_hop;
    logic                    v6_on;

    route_answer_t           answers_due [$];

    function automatic route_answer_t predict_route(input logic [63:0] hi,
                                                    input logic [63:0] lo);
        logic [127:0]  dest;
        logic [7:0]    node;
        logic [15:0]   slot;
        logic [19:0]   best;
        logic          matched;
        logic          walking;
        route_answer_t ans;
        dest    = {hi, lo};
        node    = trie_root;
        best    = '0;
        matched = 1'b0;
        walking = 1'b1;
        ans     = '0;
        if (!v6_on)
            return ans;
        for (int lvl = 0; lvl <= LAST_LEVEL; lvl++)
        begin
            if (walking)
            begin
                slot = {node, dest[127 - 8*lvl -: 8]};
                if (tbl_valid[slot])
                begin
                    matched = 1'b1;
                    best    = tbl_hop[slot];
                end
                // the child of a last-level entry is never followed
                if (lvl == LAST_LEVEL || tbl_child[slot] == CHILD_NONE)
                    walking = 1'b0;
                else
                    node = tbl_child[slot];
            end
        end
        if (matched)
        begin
            ans.hit     = 1'b1;
            ans.fwd_hop = best;
        end
        else if (dflt_on)
        begin
            ans.hit          = 1'b1;
            ans.fwd_hop      = dflt_hop;
            ans.from_default = 1'b1;
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin : watch
        route_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 65536; i++)
            begin
                tbl_child[i] = CHILD_NONE;
                tbl_valid[i] = 1'b0;
                tbl_hop[i]   = '0;
            end
            trie_root    = '0;
            dflt_on      = 1'b0;
            dflt_hop     = '0;
            v6_on        = 1'b1;
            answers_due.delete();
            mismatches   = 0;
            lookups_seen = 0;
            writes_seen  = 0;
            routed       = 0;
            defaulted    = 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROOT_NODE:        trie_root = cfg_data[7:0];
                    CFG_DEFAULT_ENABLE:   dflt_on   = cfg_data[0];
                    CFG_DEFAULT_NEXT_HOP: dflt_hop  = cfg_data;
                    CFG_IPV6_MODE:        v6_on     = cfg_data[0];
                    default: ;
                endcase
            end

            if (rsp_valid && !rsp_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected result transfer: hit %0d fwd_hop %05h from_default %0d",
                           hit, fwd_hop, from_default);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        mismatches++;
                    end
                    if (fwd_hop !== want.fwd_hop)
                    begin
                        $error("fwd_hop: expected %05h, got %05h", want.fwd_hop, fwd_hop);
                        mismatches++;
                    end
                    if (from_default !== want.from_default)
                    begin
                        $error("from_default: expected %0d, got %0d",
                               want.from_default, from_default);
                        mismatches++;
                    end
                    if (want.hit && want.from_default)
                        defaulted++;
                    else if (want.hit)
                        routed++;
                end
            end

            if (req_valid && !req_stall)
            begin
                if (kind == KIND_WRITE)
                begin
                    tbl_child[{node_index, entry_byte}] = child_index;
                    tbl_valid[{node_index, entry_byte}] = entry_valid;
                    tbl_hop[{node_index, entry_byte}]   = entry_next_hop;
                    writes_seen++;
                end
                else
                begin
                    answers_due.push_back(predict_route(addr_hi, addr_lo));
                    lookups_seen++;
                end
            end
            pending <= answers_due.size();
        end
    end

endmodule

FILE: tb/tb_ipv6_stride8_trie_lpm_lookup.sv
// Stimulus and verdict for the stride-8 IPv6 trie lookup.
`timescale 1ns / 100ps

module tb_ipv6_stride8_trie_lpm_lookup
    import ipv6lpm_pkg::*;
;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NO_REGISTER = 8'd200;
    localparam logic [127:0] DEEP_DEST = 128'hFE00_1122_3344_5566_7788_99AA_BBCC_DDEE;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 184;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;

    logic                      req_valid      = 1'b0;
    logic                      req_stall;
    logic                      kind           = KIND_LOOKUP;
    logic [63:0]               addr_hi        = '0;
    logic [63:0]               addr_lo        = '0;
    logic [7:0]                node_index     = '0;
    logic [7:0]                entry_byte     = '0;
    logic [7:0]                child_index    = '0;
    logic                      entry_valid    = 1'b0;
    logic [19:0]               entry_next_hop = '0;

    logic                      rsp_valid;
    logic                      rsp_stall      = 1'b0;
    logic                      hit;
    logic [HOP_OUT_BITS-1:0]   fwd_hop;
    logic                      from_default;

    logic                      cfg_valid      = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data       = '0;

    int mismatches;
    int pending;
    int lookups_seen;
    int writes_seen;
    int routed;
    int defaulted;

    int holds_wanted = 0;

    // generation-side view of the trie, only used to build deep paths
    logic [7:0]   gen_child [0:65535];
    logic [127:0] known_dest [$];
    logic [7:0]   cur_root;
    logic [7:0]   next_node;
    int           sent_items;
    int           burst_left;
    int           settings_used;

    always #4 clk = ~clk;

    ipv6_stride8_trie_lpm_lookup dut (.*);

    lpm_route_checker checker_i (.*);

    initial
    begin : watchdog
        #8_000_000;
        $display("tb_ipv6_stride8_trie_lpm_lookup: errors");
        $finish;
    end

    // result side: own stall pattern, plus a long hold whenever one is requested
    initial
    begin : rsp_pacing
        int seg;
        int len;
        int holds_done;
        holds_done = 0;
        forever
        begin
            if (holds_wanted > holds_done)
            begin
                holds_done++;
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else
            begin
                seg = $urandom_range(0, 3);
                len = $urandom_range(8, 80);
                repeat (len)
                begin
                    case (seg)
                        0: rsp_stall <= 1'b0;
                        1: rsp_stall <= ($urandom_range(0, 3) == 0);
                        2: rsp_stall <= ($urandom_range(0, 1) == 1);
                        default: rsp_stall <= ($urandom_range(0, 9) < 8);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic idle_req(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic offer(input logic k, input logic [127:0] dest,
                         input logic [7:0] nd, input logic [7:0] eb, input logic [7:0] kid,
                         input logic ev, input logic [19:0] hop);
        req_valid      <= 1'b1;
        kind           <= k;
        addr_hi        <= dest[127:64];
        addr_lo        <= dest[63:0];
        node_index     <= nd;
        entry_byte     <= eb;
        child_index    <= kid;
        entry_valid    <= ev;
        entry_next_hop <= hop;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent_items++;
        // keep offering inside a burst, otherwise drop valid for a gap
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(0, 24);
            idle_req($urandom_range(1, 10));
        end
    endtask

    function automatic logic [19:0] rand_hop();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 20'hFFFFF;
            default: return 20'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    function automatic logic [127:0] rand_dest();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // a stored destination with a random tail, or one left whole
    function automatic logic [127:0] near_dest();
        logic [127:0] d;
        logic [127:0] r;
        int           keep;
        r = rand_dest();
        if (known_dest.size() == 0)
            return r;
        d    = known_dest[$urandom_range(0, known_dest.size() - 1)];
        keep = ($urandom_range(0, 2) == 0) ? 16 : $urandom_range(0, 15);
        for (int b = keep; b < 16; b++)
            d[127 - 8*b -: 8] = r[127 - 8*b -: 8];
        return d;
    endfunction

    task automatic send_write(input logic [7:0] nd, input logic [7:0] eb, input logic [7:0] kid,
                              input logic ev, input logic [19:0] hop);
        gen_child[{nd, eb}] = kid;
        offer(KIND_WRITE, rand_dest(), nd, eb, kid, ev, hop);
    endtask

    task automatic send_lookup(input logic [127:0] dest);
        offer(KIND_LOOKUP, dest, 8'($urandom), 8'($urandom), 8'($urandom),
              ($urandom_range(0, 1) == 1), 20'($urandom));
    endtask

    task automatic insert_prefix();
        logic [127:0] dest;
        logic [7:0]   node;
        logic [7:0]   eb;
        logic [7:0]   kid;
        int           len;
        dest = ($urandom_range(0, 2) == 0) ? rand_dest() : near_dest();
        len  = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 16);
        node = cur_root;
        for (int lvl = 0; lvl < len; lvl++)
        begin
            eb = dest[127 - 8*lvl -: 8];
            if (lvl == len - 1)
            begin
                kid = gen_child[{node, eb}];
                if (lvl == 15 && $urandom_range(0, 1) == 1)
                    kid = 8'($urandom_range(1, 255));
                send_write(node, eb, kid, ($urandom_range(0, 9) != 0), rand_hop());
            end
            else if (gen_child[{node, eb}] != CHILD_NONE)
                node = gen_child[{node, eb}];
            else
            begin
                next_node = (next_node == 8'd255) ? 8'd2 : next_node + 8'd1;
                if (next_node == cur_root)
                    next_node = next_node + 8'd1;
                kid = next_node;
                send_write(node, eb, kid, ($urandom_range(0, 3) == 0), rand_hop());
                node = kid;
            end
        end
        known_dest.push_back(dest);
        if (known_dest.size() > 32)
            void'(known_dest.pop_front());
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] root, input logic den,
                             input logic [19:0] dhop, input logic mode);
        cfg_write(CFG_ROOT_NODE, {12'd0, root});
        cfg_write(CFG_DEFAULT_ENABLE, {19'd0, den});
        cfg_write(CFG_DEFAULT_NEXT_HOP, dhop);
        cfg_write(CFG_IPV6_MODE, {19'd0, mode});
        cfg_write(CFG_NO_REGISTER, 20'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_root = root;
        settings_used++;
    endtask

    // hold the sender until every answer is back, then let writes settle
    task automatic drain();
        idle_req(2);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] nd;
        int         sel;
        for (int i = 0; i < 65536; i++)
            gen_child[i] = CHILD_NONE;
        next_node     = 8'd60;
        sent_items    = 0;
        burst_left    = 0;
        settings_used = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(8'd1, 1'b0, 20'd0, 1'b1);
        // short chain: covering route, no-next-hop hop, valid route with next hop zero
        send_write(8'd1, 8'h20, 8'd2, 1'b1, 20'hFFFFF);
        send_write(8'd2, 8'h01, 8'd3, 1'b0, 20'h00001);
        send_write(8'd3, 8'h0D, CHILD_NONE, 1'b1, 20'h00000);
        // full-depth path; the last entry has a child that must be ignored
        for (int k = 0; k < 16; k++)
        begin
            nd = (k == 0) ? 8'd1 : 8'(39 + k);
            send_write(nd, DEEP_DEST[127 - 8*k -: 8], (k == 15) ? 8'd1 : 8'(40 + k),
                       (k == 3 || k == 15), (k == 15) ? 20'hABCDE : 20'h12345);
        end
        send_lookup({64'h2001_0D00_0000_0000, 64'h0});
        send_lookup({64'h2002_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF});
        send_lookup('0);
        send_lookup('1);
        send_lookup(DEEP_DEST);
        send_lookup(DEEP_DEST ^ 128'h1);
        known_dest.push_back(DEEP_DEST);
        known_dest.push_back({64'h2001_0D00_0000_0000, 64'h0});
        drain();

        // default route on: a miss takes it, a match does not
        configure(8'd1, 1'b1, 20'hFFFFF, 1'b1);
        send_lookup('0);
        send_lookup(DEEP_DEST);
        drain();

        // lookups disabled: nothing hits, default or not
        configure(8'd1, 1'b1, 20'hFFFFF, 1'b0);
        send_lookup(DEEP_DEST);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: configure(8'd255, 1'b1, 20'hFFFFF, 1'b1);
                1: configure(8'd0, 1'b1, 20'd0, 1'b1);
                2: configure(8'($urandom), 1'b0, 20'($urandom), 1'b1);
                3: configure(8'($urandom), 1'b1, 20'($urandom), 1'b0);
                default: configure(8'd1, 1'b1, 20'h5A5A5, 1'b1);
            endcase
            if (ph == 0 || ph == 2)
                holds_wanted <= holds_wanted + 1;
            while (sent_items < 28 + PHASE_ITEMS * (ph + 1))
            begin
                sel = $urandom_range(0, 99);
                if (sel < 30)
                    insert_prefix();
                else if (sel < 75)
                    send_lookup(near_dest());
                else if (sel < 88)
                    send_lookup(rand_dest());
                else
                    send_write(8'($urandom), 8'($urandom),
                               ($urandom_range(0, 3) == 0) ? CHILD_NONE : 8'($urandom),
                               ($urandom_range(0, 1) == 1), rand_hop());
            end
            drain();
        end

        $display("swept %0d register settings: %0d table writes, %0d lookups", settings_used,
                 writes_seen, lookups_seen);
        $display("answers: %0d from stored routes, %0d from the default route", routed, defaulted);
        if (mismatches == 0)
            $display("tb_ipv6_stride8_trie_lpm_lookup: clean");
        else
            $display("tb_ipv6_stride8_trie_lpm_lookup: errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ipv6lpm_pkg.sv
sv/ipv6lpm_ram.sv
sv/ipv6_stride8_trie_lpm_lookup.sv
tb/lpm_route_checker.sv
tb/tb_ipv6_stride8_trie_lpm_lookup.sv
